// ===== hdl/pvtf_pkg.sv =====
package pvtf_pkg;

   localparam int ADDR_W = 10;
   localparam int DEPTH  = 1 << ADDR_W;

   localparam int POS_W = 24;
   localparam int UV_W  = 24;
   localparam int NRM_W = 16;
   localparam int SUM_W = 20;
   localparam int OUT_W = 16;
   localparam int EPS_W = 24;
   localparam int CSR_W = 32;

   // edge and uv delta width
   localparam int E_W = POS_W + 1;

   // shared multiplier and accumulator
   localparam int MA_W   = 28;
   localparam int MB_W   = 40;
   localparam int PROD_W = MA_W + MB_W;
   localparam int ACC_W  = 62;

   // sequential divider
   localparam int DIV_W     = 52;
   localparam int FEED_W    = 19;
   localparam int NORM_ITER = 15;

   // square root
   localparam int SQ_W  = 58;
   localparam int LEN_W = 29;

   localparam int P_W   = 28;
   localparam int CR_W  = 34;
   localparam int FRAC_SHIFT = 28;
   localparam int P_SHIFT    = 24;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [OUT_W-1:0] ONE_Q14 = OUT_W'(16384);

   typedef enum logic [1:0] {
      CMD_LOAD = 2'd0,
      CMD_TRI  = 2'd1,
      CMD_READ = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MAC_NONE,
      MAC_LOAD,
      MAC_ADD,
      MAC_SUB
   } mac_type;

   typedef enum logic [5:0] {
      S_CLEAR,
      S_IDLE,
      T_RDB,
      T_RDC,
      T_CAP,
      T_DET,
      T_DETW,
      T_DETCHK,
      T_NUM,
      T_NUMW,
      T_DIVSET,
      T_DIV,
      T_DIVEND,
      T_ACCRD,
      T_ACCWR,
      R_CAP,
      R_S,
      R_SW,
      R_SCHK,
      R_D,
      R_DW,
      R_DCAP,
      R_P,
      R_PW,
      R_PCAP,
      R_Q,
      R_QW,
      R_SQSET,
      R_SQ,
      R_SQEND,
      R_NSET,
      R_NDIV,
      R_NEND,
      R_CR,
      R_CRW,
      R_CRCAP,
      R_H,
      R_HW,
      R_HCHK
   } state_type;

   typedef struct packed {
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      logic signed [POS_W-1:0] pz;
      logic signed [UV_W-1:0]  u;
      logic signed [UV_W-1:0]  v;
      logic signed [NRM_W-1:0] nx;
      logic signed [NRM_W-1:0] ny;
      logic signed [NRM_W-1:0] nz;
   } vtx_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] tx;
      logic signed [SUM_W-1:0] ty;
      logic signed [SUM_W-1:0] tz;
      logic signed [SUM_W-1:0] bx;
      logic signed [SUM_W-1:0] by;
      logic signed [SUM_W-1:0] bz;
   } sums_type;

   function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                       input logic signed [SUM_W-1:0] b);
      logic signed [SUM_W:0] s;
      s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
      if (s > (SUM_W+1)'(SUM_MAX)) begin
         return SUM_MAX;
      end else if (s < (SUM_W+1)'(SUM_MIN)) begin
         return SUM_MIN;
      end
      return s[SUM_W-1:0];
   endfunction

   // cyclic successor among the three components
   function automatic logic [1:0] next3(input logic [1:0] k);
      case (k)
         2'd0: return 2'd1;
         2'd1: return 2'd2;
         default: return 2'd0;
      endcase
   endfunction

endpackage

// ===== hdl/per_vertex_tangent_frame_top.sv =====
// add triangle: three vertex reads, then, unless the determinant is too small, six 19-step divisions
//   through one shared divider and three sum read-modify-writes
// read vertex: one shared multiplier, 29-step square root, three 15-step divisions, ending in the
//   rsp_valid strobe; one item at a time, start is taken while busy is low
// reset: synchronous; the threshold registers return to 1 and a clearing pass over all 1024 entries zeroes
//   the sum memory with busy high; results are strobed for one cycle, the receiver cannot stall
module per_vertex_tangent_frame_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_command,
   input  logic signed [pvtf_pkg::POS_W-1:0] req_pos_x,
   input  logic signed [pvtf_pkg::POS_W-1:0] req_pos_y,
   input  logic signed [pvtf_pkg::POS_W-1:0] req_pos_z,
   input  logic signed [pvtf_pkg::NRM_W-1:0] req_norm_x,
   input  logic signed [pvtf_pkg::NRM_W-1:0] req_norm_y,
   input  logic signed [pvtf_pkg::NRM_W-1:0] req_norm_z,
   input  logic signed [pvtf_pkg::UV_W-1:0]  req_tex_u,
   input  logic signed [pvtf_pkg::UV_W-1:0]  req_tex_v,
   input  logic [pvtf_pkg::ADDR_W-1:0]       req_index_a,
   input  logic [pvtf_pkg::ADDR_W-1:0]       req_index_b,
   input  logic [pvtf_pkg::ADDR_W-1:0]       req_index_c,
   output logic                              rsp_valid,
   output logic [pvtf_pkg::ADDR_W-1:0]       rsp_vertex_index,
   output logic signed [pvtf_pkg::OUT_W-1:0] rsp_tangent_x,
   output logic signed [pvtf_pkg::OUT_W-1:0] rsp_tangent_y,
   output logic signed [pvtf_pkg::OUT_W-1:0] rsp_tangent_z,
   output logic                              rsp_handedness,
   output logic                              rsp_used_default,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [2:0]                        csr_paddr,
   input  logic [pvtf_pkg::CSR_W-1:0]        csr_pwdata,
   output logic [pvtf_pkg::CSR_W-1:0]        csr_prdata,
   output logic                              csr_pready
);
   import pvtf_pkg::*;

   state_type state_ff, state_in;
   logic [4:0] ctr_ff;
   logic [1:0] k_ff;
   logic       which_ff;
   logic [1:0] corner_ff;
   logic [ADDR_W-1:0] clr_ff;
   logic [ADDR_W-1:0] a_ff, b_ff, c_ff;

   logic [EPS_W-1:0] eps_uv_ff, eps_len_ff;

   vtx_type  vmem [DEPTH];
   sums_type smem [DEPTH];
   vtx_type  v_q;
   sums_type s_q;
   logic [ADDR_W-1:0] v_raddr, s_raddr, s_waddr, corner_idx;
   logic     v_we, s_we;
   sums_type s_wdata, s_upd;

   vtx_type base_ff;
   logic signed [E_W-1:0] e1_ff [0:2];
   logic signed [E_W-1:0] e2_ff [0:2];
   logic signed [E_W-1:0] du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic [DIV_W-1:0] ud_ff;
   logic det_neg_ff, num_neg_ff, sat_ff;
   logic signed [SUM_W-1:0] tv_ff [0:2];
   logic signed [SUM_W-1:0] bv_ff [0:2];

   logic signed [SUM_W-1:0] t_ff  [0:2];
   logic signed [NRM_W-1:0] n_ff  [0:2];
   logic signed [SUM_W-1:0] bs_ff [0:2];
   logic signed [MB_W-1:0]  d_ff;
   logic signed [P_W-1:0]   p_ff  [0:2];
   logic signed [OUT_W-1:0] o_ff  [0:2];
   logic signed [CR_W-1:0]  cr_ff [0:2];

   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   mac_type                  mac_op, mode_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [ACC_W-1:0]         acc_mag;

   logic [DIV_W-1:0]  div_rem_ff, div_den_ff, div_shift, div_diff;
   logic [FEED_W-1:0] div_feed_ff, div_q_ff;
   logic              div_ge;

   logic [SQ_W-1:0] sq_s_ff, sq_r_ff, sq_bit_ff, sq_t;

   logic [P_W-1:0]    p_mag;
   logic [P_W+13:0]   norm_num;
   logic signed [SUM_W-1:0] div_val;
   logic [1:0] k1, k2;

   logic accept, finish, fin_def;
   logic rsp_valid_ff;
   logic [ADDR_W-1:0] rsp_index_ff;
   logic signed [OUT_W-1:0] rsp_tx_ff, rsp_ty_ff, rsp_tz_ff;
   logic rsp_hand_ff, rsp_def_ff;
   logic csr_wr;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = csr_paddr[2] ? CSR_W'(eps_len_ff) : CSR_W'(eps_uv_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_uv_ff  <= EPS_W'(1);
         eps_len_ff <= EPS_W'(1);
      end else if (csr_wr) begin
         if (csr_paddr[2]) begin
            eps_len_ff <= csr_pwdata[EPS_W-1:0];
         end else begin
            eps_uv_ff <= csr_pwdata[EPS_W-1:0];
         end
      end
   end

   // memories
   always_comb begin
      case (corner_ff)
         2'd0: corner_idx = a_ff;
         2'd1: corner_idx = b_ff;
         default: corner_idx = c_ff;
      endcase
   end

   always_comb begin
      s_upd.tx = sat_add(s_q.tx, tv_ff[0]);
      s_upd.ty = sat_add(s_q.ty, tv_ff[1]);
      s_upd.tz = sat_add(s_q.tz, tv_ff[2]);
      s_upd.bx = sat_add(s_q.bx, bv_ff[0]);
      s_upd.by = sat_add(s_q.by, bv_ff[1]);
      s_upd.bz = sat_add(s_q.bz, bv_ff[2]);
   end

   always_comb begin
      case (state_ff)
         S_IDLE:  v_raddr = req_index_a;
         T_RDB:   v_raddr = b_ff;
         T_RDC:   v_raddr = c_ff;
         default: v_raddr = a_ff;
      endcase
      case (state_ff)
         S_IDLE:  s_raddr = req_index_a;
         default: s_raddr = corner_idx;
      endcase
      v_we    = accept && (req_command == CMD_LOAD);
      s_we    = 1'b0;
      s_waddr = req_index_a;
      s_wdata = '0;
      case (state_ff)
         S_CLEAR: begin
            s_we    = 1'b1;
            s_waddr = clr_ff;
         end
         S_IDLE: begin
            s_we = v_we;
         end
         T_ACCWR: begin
            s_we    = 1'b1;
            s_waddr = corner_idx;
            s_wdata = s_upd;
         end
         default: begin
            s_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (v_we) begin
         vmem[req_index_a] <= '{px: req_pos_x, py: req_pos_y, pz: req_pos_z,
                                u: req_tex_u, v: req_tex_v,
                                nx: req_norm_x, ny: req_norm_y, nz: req_norm_z};
      end
      v_q <= vmem[v_raddr];
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         smem[s_waddr] <= s_wdata;
      end
      s_q <= smem[s_raddr];
   end

   // shared divider step and square root step
   assign div_shift = {div_rem_ff[DIV_W-2:0], div_feed_ff[FEED_W-1]};
   assign div_ge    = (div_shift >= div_den_ff);
   assign div_diff  = div_shift - div_den_ff;
   assign sq_t      = sq_r_ff + sq_bit_ff;

   assign acc_mag  = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign p_mag    = p_ff[k_ff][P_W-1] ? P_W'(-p_ff[k_ff]) : P_W'(p_ff[k_ff]);
   assign norm_num = {p_mag, 14'h0} + (P_W+14)'(sq_r_ff[LEN_W-1:1]);
   assign k1 = next3(k_ff);
   assign k2 = next3(k1);

   always_comb begin
      if (sat_ff) begin
         div_val = (num_neg_ff ^ det_neg_ff) ? SUM_MIN : SUM_MAX;
      end else if (num_neg_ff ^ det_neg_ff) begin
         div_val = -SUM_W'({1'b0, div_q_ff});
      end else begin
         div_val = SUM_W'({1'b0, div_q_ff});
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      mac_op   = MAC_NONE;
      mul_a    = '0;
      mul_b    = '0;
      finish   = 1'b0;
      fin_def  = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == ADDR_W'(DEPTH-1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_TRI:  state_in = T_RDB;
                  CMD_READ: state_in = R_CAP;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         T_RDB: state_in = T_RDC;
         T_RDC: state_in = T_CAP;
         T_CAP: state_in = T_DET;
         T_DET: begin
            if (ctr_ff[0]) begin
               mul_a    = MA_W'(du2_ff);
               mul_b    = MB_W'(dv1_ff);
               mac_op   = MAC_SUB;
               state_in = T_DETW;
            end else begin
               mul_a  = MA_W'(du1_ff);
               mul_b  = MB_W'(dv2_ff);
               mac_op = MAC_LOAD;
            end
         end
         T_DETW: state_in = T_DETCHK;
         T_DETCHK: begin
            if (acc_mag <= ACC_W'({eps_uv_ff, 16'h0})) state_in = S_IDLE;
            else state_in = T_NUM;
         end
         T_NUM: begin
            if (ctr_ff[0]) begin
               mul_a    = which_ff ? MA_W'(du2_ff) : MA_W'(dv1_ff);
               mul_b    = which_ff ? MB_W'(e1_ff[k_ff]) : MB_W'(e2_ff[k_ff]);
               mac_op   = MAC_SUB;
               state_in = T_NUMW;
            end else begin
               mul_a  = which_ff ? MA_W'(du1_ff) : MA_W'(dv2_ff);
               mul_b  = which_ff ? MB_W'(e2_ff[k_ff]) : MB_W'(e1_ff[k_ff]);
               mac_op = MAC_LOAD;
            end
         end
         T_NUMW:   state_in = T_DIVSET;
         T_DIVSET: state_in = T_DIV;
         T_DIV: begin
            if (ctr_ff == 5'(FEED_W-1)) state_in = T_DIVEND;
         end
         T_DIVEND: begin
            if (which_ff && (k_ff == 2'd2)) state_in = T_ACCRD;
            else state_in = T_NUM;
         end
         T_ACCRD: state_in = T_ACCWR;
         T_ACCWR: begin
            if (corner_ff == 2'd2) state_in = S_IDLE;
            else state_in = T_ACCRD;
         end
         R_CAP: state_in = R_S;
         R_S: begin
            case (ctr_ff[1:0])
               2'd0: begin
                  mul_a  = MA_W'(t_ff[0]);
                  mul_b  = MB_W'(t_ff[0]);
                  mac_op = MAC_LOAD;
               end
               2'd1: begin
                  mul_a  = MA_W'(t_ff[1]);
                  mul_b  = MB_W'(t_ff[1]);
                  mac_op = MAC_ADD;
               end
               2'd2: begin
                  mul_a  = MA_W'(t_ff[2]);
                  mul_b  = MB_W'(t_ff[2]);
                  mac_op = MAC_ADD;
               end
               default: begin
                  mul_a    = MA_W'($signed({1'b0, eps_len_ff}));
                  mul_b    = MB_W'($signed({1'b0, eps_len_ff}));
                  mac_op   = MAC_SUB;
                  state_in = R_SW;
               end
            endcase
         end
         R_SW: state_in = R_SCHK;
         R_SCHK: begin
            if (acc_ff[ACC_W-1]) begin
               finish   = 1'b1;
               fin_def  = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = R_D;
            end
         end
         R_D: begin
            mul_a  = MA_W'(t_ff[ctr_ff[1:0]]);
            mul_b  = MB_W'(n_ff[ctr_ff[1:0]]);
            mac_op = (ctr_ff == 5'd0) ? MAC_LOAD : MAC_ADD;
            if (ctr_ff == 5'd2) state_in = R_DW;
         end
         R_DW:   state_in = R_DCAP;
         R_DCAP: state_in = R_P;
         R_P: begin
            if (ctr_ff[0]) begin
               mul_a    = MA_W'(n_ff[k_ff]);
               mul_b    = d_ff;
               mac_op   = MAC_SUB;
               state_in = R_PW;
            end else begin
               mul_a  = MA_W'(t_ff[k_ff]);
               mul_b  = MB_W'(1) <<< FRAC_SHIFT;
               mac_op = MAC_LOAD;
            end
         end
         R_PW: state_in = R_PCAP;
         R_PCAP: begin
            if (k_ff == 2'd2) state_in = R_Q;
            else state_in = R_P;
         end
         R_Q: begin
            mul_a  = MA_W'(p_ff[ctr_ff[1:0]]);
            mul_b  = MB_W'(p_ff[ctr_ff[1:0]]);
            mac_op = (ctr_ff == 5'd0) ? MAC_LOAD : MAC_ADD;
            if (ctr_ff == 5'd2) state_in = R_QW;
         end
         R_QW:    state_in = R_SQSET;
         R_SQSET: state_in = R_SQ;
         R_SQ: begin
            if (ctr_ff == 5'(SQ_W/2-1)) state_in = R_SQEND;
         end
         R_SQEND: begin
            if (sq_r_ff == '0) begin
               finish   = 1'b1;
               fin_def  = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = R_NSET;
            end
         end
         R_NSET: state_in = R_NDIV;
         R_NDIV: begin
            if (ctr_ff == 5'(NORM_ITER-1)) state_in = R_NEND;
         end
         R_NEND: begin
            if (k_ff == 2'd2) state_in = R_CR;
            else state_in = R_NSET;
         end
         R_CR: begin
            // cross(n, o) component k
            if (ctr_ff[0]) begin
               mul_a    = MA_W'(n_ff[k2]);
               mul_b    = MB_W'(o_ff[k1]);
               mac_op   = MAC_SUB;
               state_in = R_CRW;
            end else begin
               mul_a  = MA_W'(n_ff[k1]);
               mul_b  = MB_W'(o_ff[k2]);
               mac_op = MAC_LOAD;
            end
         end
         R_CRW: state_in = R_CRCAP;
         R_CRCAP: begin
            if (k_ff == 2'd2) state_in = R_H;
            else state_in = R_CR;
         end
         R_H: begin
            mul_a  = MA_W'(bs_ff[ctr_ff[1:0]]);
            mul_b  = MB_W'(cr_ff[ctr_ff[1:0]]);
            mac_op = (ctr_ff == 5'd0) ? MAC_LOAD : MAC_ADD;
            if (ctr_ff == 5'd2) state_in = R_HW;
         end
         R_HW: state_in = R_HCHK;
         R_HCHK: begin
            finish   = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ctr_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MAC_NONE;
      end else begin
         state_ff     <= state_in;
         ctr_ff       <= (state_in != state_ff) ? 5'd0 : ctr_ff + 5'd1;
         clr_ff       <= (state_ff == S_CLEAR) ? clr_ff + ADDR_W'(1) : clr_ff;
         rsp_valid_ff <= finish;
         mode_ff      <= mac_op;
      end
   end

   // multiply-accumulate, product registered ahead of the accumulator
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (mode_ff)
         MAC_LOAD: acc_ff <= prod_ff[ACC_W-1:0];
         MAC_ADD:  acc_ff <= acc_ff + prod_ff[ACC_W-1:0];
         MAC_SUB:  acc_ff <= acc_ff - prod_ff[ACC_W-1:0];
         default:  acc_ff <= acc_ff;
      endcase
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            a_ff <= req_index_a;
            b_ff <= req_index_b;
            c_ff <= req_index_c;
         end
         T_RDB: base_ff <= v_q;
         T_RDC: begin
            e1_ff[0] <= E_W'(v_q.px) - E_W'(base_ff.px);
            e1_ff[1] <= E_W'(v_q.py) - E_W'(base_ff.py);
            e1_ff[2] <= E_W'(v_q.pz) - E_W'(base_ff.pz);
            du1_ff   <= E_W'(v_q.u) - E_W'(base_ff.u);
            dv1_ff   <= E_W'(v_q.v) - E_W'(base_ff.v);
         end
         T_CAP: begin
            e2_ff[0] <= E_W'(v_q.px) - E_W'(base_ff.px);
            e2_ff[1] <= E_W'(v_q.py) - E_W'(base_ff.py);
            e2_ff[2] <= E_W'(v_q.pz) - E_W'(base_ff.pz);
            du2_ff   <= E_W'(v_q.u) - E_W'(base_ff.u);
            dv2_ff   <= E_W'(v_q.v) - E_W'(base_ff.v);
         end
         T_DETCHK: begin
            ud_ff      <= acc_mag[DIV_W-1:0];
            det_neg_ff <= acc_ff[ACC_W-1];
            k_ff       <= 2'd0;
            which_ff   <= 1'b0;
         end
         T_DIVSET: begin
            num_neg_ff  <= acc_ff[ACC_W-1];
            sat_ff      <= (acc_mag >= ACC_W'({ud_ff, 3'b000}));
            div_rem_ff  <= acc_mag[DIV_W+2:3];
            div_feed_ff <= {acc_mag[2:0], 16'h0};
            div_den_ff  <= ud_ff;
            div_q_ff    <= '0;
         end
         T_DIV, R_NDIV: begin
            div_rem_ff  <= div_ge ? div_diff : div_shift;
            div_feed_ff <= {div_feed_ff[FEED_W-2:0], 1'b0};
            div_q_ff    <= {div_q_ff[FEED_W-2:0], div_ge};
         end
         T_DIVEND: begin
            if (which_ff) begin
               bv_ff[k_ff] <= div_val;
               k_ff        <= next3(k_ff);
            end else begin
               tv_ff[k_ff] <= div_val;
            end
            which_ff  <= !which_ff;
            corner_ff <= 2'd0;
         end
         T_ACCWR: corner_ff <= corner_ff + 2'd1;
         R_CAP: begin
            t_ff[0]  <= s_q.tx;
            t_ff[1]  <= s_q.ty;
            t_ff[2]  <= s_q.tz;
            bs_ff[0] <= s_q.bx;
            bs_ff[1] <= s_q.by;
            bs_ff[2] <= s_q.bz;
            n_ff[0]  <= v_q.nx;
            n_ff[1]  <= v_q.ny;
            n_ff[2]  <= v_q.nz;
         end
         R_DCAP: begin
            d_ff <= acc_ff[MB_W-1:0];
            k_ff <= 2'd0;
         end
         R_PCAP: begin
            // floor of the exact projection to 20 fraction bits
            p_ff[k_ff] <= acc_ff[P_SHIFT+P_W-1:P_SHIFT];
            k_ff       <= next3(k_ff);
         end
         R_SQSET: begin
            sq_s_ff   <= acc_ff[SQ_W-1:0];
            sq_r_ff   <= '0;
            sq_bit_ff <= SQ_W'(1) << (SQ_W-2);
            k_ff      <= 2'd0;
         end
         R_SQ: begin
            if (sq_s_ff >= sq_t) begin
               sq_s_ff <= sq_s_ff - sq_t;
               sq_r_ff <= (sq_r_ff >> 1) + sq_bit_ff;
            end else begin
               sq_r_ff <= sq_r_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
         end
         R_NSET: begin
            div_rem_ff  <= DIV_W'(norm_num[P_W+13:NORM_ITER]);
            div_feed_ff <= {norm_num[NORM_ITER-1:0], (FEED_W-NORM_ITER)'(0)};
            div_den_ff  <= DIV_W'(sq_r_ff[LEN_W-1:0]);
            div_q_ff    <= '0;
         end
         R_NEND: begin
            o_ff[k_ff] <= p_ff[k_ff][P_W-1] ? -OUT_W'({1'b0, div_q_ff[NORM_ITER-1:0]})
                                            : OUT_W'({1'b0, div_q_ff[NORM_ITER-1:0]});
            k_ff       <= next3(k_ff);
         end
         R_CRCAP: begin
            cr_ff[k_ff] <= acc_ff[CR_W-1:0];
            k_ff        <= next3(k_ff);
         end
         default: begin
            k_ff <= k_ff;
         end
      endcase
   end

   // result registers
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_index_ff <= a_ff;
         if (fin_def) begin
            rsp_tx_ff   <= ONE_Q14;
            rsp_ty_ff   <= '0;
            rsp_tz_ff   <= '0;
            rsp_hand_ff <= 1'b0;
            rsp_def_ff  <= 1'b1;
         end else begin
            rsp_tx_ff   <= o_ff[0];
            rsp_ty_ff   <= o_ff[1];
            rsp_tz_ff   <= o_ff[2];
            rsp_hand_ff <= acc_ff[ACC_W-1];
            rsp_def_ff  <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_index = rsp_index_ff;
   assign rsp_tangent_x    = rsp_tx_ff;
   assign rsp_tangent_y    = rsp_ty_ff;
   assign rsp_tangent_z    = rsp_tz_ff;
   assign rsp_handedness   = rsp_hand_ff;
   assign rsp_used_default = rsp_def_ff;

`ifndef SYNTHESIS
   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_result_after_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a command in progress");

   a_clear_busy : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> busy)
      else $error("transfer possible during sum clearing");

   a_sum_write_rmw : assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_ACCWR) |-> $past(state_ff == T_ACCRD))
      else $error("sum write without a preceding read");
`endif

endmodule

// ===== verif/per_vertex_tangent_frame_top_tb.sv =====
module per_vertex_tangent_frame_top_tb;
   import pvtf_pkg::*;

   localparam int NVTX       = 1024;
   localparam int CYCLE_CAP  = 2000000;
   localparam int DRAIN      = 250;
   localparam int PHASE_ITEMS = 390;

   typedef struct {
      cmd_type                   cmd;
      logic signed [POS_W-1:0]   px, py, pz;
      logic signed [NRM_W-1:0]   nx, ny, nz;
      logic signed [UV_W-1:0]    u, v;
      logic [ADDR_W-1:0]         ia, ib, ic;
   } vtx_cmd_t;

   typedef struct {
      logic [ADDR_W-1:0]         idx;
      logic signed [OUT_W-1:0]   tx, ty, tz;
      logic                      hand;
      logic                      dflt;
   } frame_t;

   class tangent_scoreboard;
      longint pos[3][NVTX];
      longint uvs[2][NVTX];
      longint nrm[3][NVTX];
      longint tsum[3][NVTX];
      longint bsum[3][NVTX];
      longint unsigned det_eps, len_eps;
      frame_t frames_due[$];
      int errors;

      function new();
         det_eps = 1;
         len_eps = 1;
         errors = 0;
         for (int i = 0; i < NVTX; i++) begin
            for (int k = 0; k < 3; k++) begin
               pos[k][i] = 0; nrm[k][i] = 0; tsum[k][i] = 0; bsum[k][i] = 0;
            end
            uvs[0][i] = 0; uvs[1][i] = 0;
         end
      endfunction

      function void report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endfunction

      function longint clamp20(longint x);
         if (x > 524287) return 524287;
         if (x < -524288) return -524288;
         return x;
      endfunction

      function longint unsigned absval(longint x);
         return x < 0 ? longint'(-x) : longint'(x);
      endfunction

      // num/den with 16 fraction bits, truncated toward zero
      function longint frac_div(longint num, longint den);
         longint unsigned un, ud, q, r;
         bit sat;
         un = absval(num);
         ud = absval(den);
         q = un / ud;
         r = un % ud;
         sat = 0;
         for (int k = 0; k < 16; k++) begin
            if (q >= (64'd1 << 20)) begin
               sat = 1;
               break;
            end
            q = q << 1;
            r = r << 1;
            if (r >= ud) begin
               r = r - ud;
               q = q | 1;
            end
         end
         if (sat || q > (64'd1 << 20)) q = 64'd1 << 20;
         if ((num < 0) != (den < 0)) return clamp20(-longint'(q));
         return clamp20(longint'(q));
      endfunction

      function longint unsigned int_sqrt(longint unsigned s);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > s) b = b >> 2;
         while (b != 0) begin
            if (s >= r + b) begin
               s = s - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function void accumulate(int vi, longint tv[3], longint bv[3]);
         for (int k = 0; k < 3; k++) begin
            tsum[k][vi] = clamp20(tsum[k][vi] + tv[k]);
            bsum[k][vi] = clamp20(bsum[k][vi] + bv[k]);
         end
      endfunction

      function void add_triangle(int a, int b, int c);
         longint e1[3], e2[3], tv[3], bv[3];
         longint du1, dv1, du2, dv2, det;
         for (int k = 0; k < 3; k++) begin
            e1[k] = pos[k][b] - pos[k][a];
            e2[k] = pos[k][c] - pos[k][a];
         end
         du1 = uvs[0][b] - uvs[0][a];
         dv1 = uvs[1][b] - uvs[1][a];
         du2 = uvs[0][c] - uvs[0][a];
         dv2 = uvs[1][c] - uvs[1][a];
         det = du1 * dv2 - du2 * dv1;
         if (absval(det) <= (det_eps << 16)) return;
         for (int k = 0; k < 3; k++) begin
            tv[k] = frac_div(dv2 * e1[k] - dv1 * e2[k], det);
            bv[k] = frac_div(du1 * e2[k] - du2 * e1[k], det);
         end
         accumulate(a, tv, bv);
         accumulate(b, tv, bv);
         accumulate(c, tv, bv);
      endfunction

      function frame_t tangent_frame(int vi);
         frame_t f;
         longint t[3], n[3], p[3], o[3], cr[3];
         longint d, hd;
         longint unsigned s, len, q;
         bit dflt;
         dflt = 0;
         s = 0;
         for (int k = 0; k < 3; k++) begin
            t[k] = tsum[k][vi];
            n[k] = nrm[k][vi];
            s += longint'(t[k] * t[k]);
         end
         if (s < len_eps * len_eps) begin
            dflt = 1;
         end else begin
            d = n[0] * t[0] + n[1] * t[1] + n[2] * t[2];
            s = 0;
            for (int k = 0; k < 3; k++) begin
               p[k] = (t[k] * (longint'(1) << 28) - n[k] * d) >>> 24;
               s += longint'(p[k] * p[k]);
            end
            len = int_sqrt(s);
            if (len == 0) begin
               dflt = 1;
            end else begin
               for (int k = 0; k < 3; k++) begin
                  q = (absval(p[k]) * 16384 + len / 2) / len;
                  if (q > 16384) q = 16384;
                  o[k] = p[k] < 0 ? -longint'(q) : longint'(q);
               end
            end
         end
         f.idx = vi;
         if (dflt) begin
            f.tx = 16384; f.ty = 0; f.tz = 0; f.hand = 0; f.dflt = 1;
            return f;
         end
         cr[0] = n[1] * o[2] - n[2] * o[1];
         cr[1] = n[2] * o[0] - n[0] * o[2];
         cr[2] = n[0] * o[1] - n[1] * o[0];
         hd = 0;
         for (int k = 0; k < 3; k++) hd += cr[k] * bsum[k][vi];
         f.tx = o[0]; f.ty = o[1]; f.tz = o[2];
         f.hand = hd < 0;
         f.dflt = 0;
         return f;
      endfunction

      function void note(vtx_cmd_t it);
         case (it.cmd)
            CMD_LOAD: begin
               pos[0][it.ia] = it.px; pos[1][it.ia] = it.py; pos[2][it.ia] = it.pz;
               nrm[0][it.ia] = it.nx; nrm[1][it.ia] = it.ny; nrm[2][it.ia] = it.nz;
               uvs[0][it.ia] = it.u;  uvs[1][it.ia] = it.v;
               for (int k = 0; k < 3; k++) begin
                  tsum[k][it.ia] = 0;
                  bsum[k][it.ia] = 0;
               end
            end
            CMD_TRI:  add_triangle(it.ia, it.ib, it.ic);
            CMD_READ: frames_due.push_back(tangent_frame(it.ia));
            default: ;
         endcase
      endfunction

      function void check(frame_t got);
         frame_t w;
         if (frames_due.size() == 0) begin
            report($sformatf("unexpected result for vertex %0d", got.idx));
            return;
         end
         w = frames_due.pop_front();
         if (got.idx !== w.idx)
            report($sformatf("vertex_index %0d, want %0d", got.idx, w.idx));
         if (got.tx !== w.tx)
            report($sformatf("v%0d tangent_x %0d, want %0d", w.idx, got.tx, w.tx));
         if (got.ty !== w.ty)
            report($sformatf("v%0d tangent_y %0d, want %0d", w.idx, got.ty, w.ty));
         if (got.tz !== w.tz)
            report($sformatf("v%0d tangent_z %0d, want %0d", w.idx, got.tz, w.tz));
         if (got.hand !== w.hand)
            report($sformatf("v%0d handedness %0b, want %0b", w.idx, got.hand, w.hand));
         if (got.dflt !== w.dflt)
            report($sformatf("v%0d used_default %0b, want %0b", w.idx, got.dflt, w.dflt));
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [1:0] req_command = 0;
   logic signed [POS_W-1:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic signed [NRM_W-1:0] req_norm_x = 0, req_norm_y = 0, req_norm_z = 0;
   logic signed [UV_W-1:0] req_tex_u = 0, req_tex_v = 0;
   logic [ADDR_W-1:0] req_index_a = 0, req_index_b = 0, req_index_c = 0;
   logic rsp_valid;
   logic [ADDR_W-1:0] rsp_vertex_index;
   logic signed [OUT_W-1:0] rsp_tangent_x, rsp_tangent_y, rsp_tangent_z;
   logic rsp_handedness, rsp_used_default;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0] csr_paddr = 0;
   logic [CSR_W-1:0] csr_pwdata = 0;
   logic [CSR_W-1:0] csr_prdata;
   logic csr_pready;

   per_vertex_tangent_frame_top dut (.*);

   tangent_scoreboard sb = new();
   int cycles = 0;
   bit loaded[NVTX];
   int pool[$];

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      frame_t got;
      if (!reset && rsp_valid) begin
         got.idx = rsp_vertex_index;
         got.tx = rsp_tangent_x; got.ty = rsp_tangent_y; got.tz = rsp_tangent_z;
         got.hand = rsp_handedness;
         got.dflt = rsp_used_default;
         sb.check(got);
      end
   end

   task automatic send(vtx_cmd_t it, int gap);
      start <= 1;
      req_command <= it.cmd;
      req_pos_x <= it.px; req_pos_y <= it.py; req_pos_z <= it.pz;
      req_norm_x <= it.nx; req_norm_y <= it.ny; req_norm_z <= it.nz;
      req_tex_u <= it.u; req_tex_v <= it.v;
      req_index_a <= it.ia; req_index_b <= it.ib; req_index_c <= it.ic;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      sb.note(it);
      if (it.cmd == CMD_LOAD && !loaded[it.ia]) begin
         loaded[it.ia] = 1;
         pool.push_back(it.ia);
      end
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic csr_write(int idx, logic [CSR_W-1:0] val);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= 3'(4 * idx); csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      // read back
      csr_psel <= 1; csr_paddr <= 3'(4 * idx);
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0;
      if (csr_prdata[EPS_W-1:0] !== val[EPS_W-1:0])
         sb.report($sformatf("csr %0d reads %h, want %h", idx, csr_prdata, val));
      if (idx == 0) sb.det_eps = val[EPS_W-1:0];
      else sb.len_eps = val[EPS_W-1:0];
   endtask

   task automatic settle();
      start <= 0;
      while (sb.frames_due.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic vtx_cmd_t noise_item(cmd_type c);
      vtx_cmd_t it;
      it.cmd = c;
      it.px = $urandom; it.py = $urandom; it.pz = $urandom;
      it.nx = $urandom_range(32768) - 16384;
      it.ny = $urandom_range(32768) - 16384;
      it.nz = $urandom_range(32768) - 16384;
      it.u = $urandom; it.v = $urandom;
      it.ia = $urandom; it.ib = $urandom; it.ic = $urandom;
      return it;
   endfunction

   function automatic vtx_cmd_t load_item(int vi, int px, int py, int pz, int nx, int ny,
                                          int nz, int u, int v);
      vtx_cmd_t it;
      it = noise_item(CMD_LOAD);
      it.ia = vi;
      it.px = px; it.py = py; it.pz = pz;
      it.nx = nx; it.ny = ny; it.nz = nz;
      it.u = u; it.v = v;
      return it;
   endfunction

   function automatic vtx_cmd_t idx_item(cmd_type c, int a, int b, int c2);
      vtx_cmd_t it;
      it = noise_item(c);
      it.ia = a; it.ib = b; it.ic = c2;
      return it;
   endfunction

   function automatic int pick_vertex();
      if ($urandom_range(9) < 8) return pool[$urandom_range(pool.size() < 24 ? pool.size() - 1 : 23)];
      return pool[$urandom_range(pool.size() - 1)];
   endfunction

   function automatic vtx_cmd_t random_item();
      vtx_cmd_t it;
      int r, sh;
      r = $urandom_range(99);
      if (r < 2) return noise_item(CMD_NONE);
      if (r < 30) begin
         it = noise_item(CMD_LOAD);
         if ($urandom_range(3) != 0) it.ia = $urandom_range(31);
         sh = $urandom_range(3);
         if (sh != 0) begin
            // mostly modest geometry so sums stay off the rails
            it.px = $signed(it.px) >>> (sh * 4);
            it.py = $signed(it.py) >>> (sh * 4);
            it.pz = $signed(it.pz) >>> (sh * 4);
            it.u = $signed(it.u) >>> (sh * 4);
            it.v = $signed(it.v) >>> (sh * 4);
         end
         if ($urandom_range(2) == 0) begin
            it.nx = 0; it.ny = 0; it.nz = 0;
            case ($urandom_range(2))
               0: it.nx = $urandom_range(1) ? 16384 : -16384;
               1: it.ny = $urandom_range(1) ? 16384 : -16384;
               default: it.nz = $urandom_range(1) ? 16384 : -16384;
            endcase
         end
         return it;
      end
      if (r < 70) return idx_item(CMD_TRI, pick_vertex(), pick_vertex(), pick_vertex());
      return idx_item(CMD_READ, pick_vertex(), 0, 0);
   endfunction

   task automatic run_random(int n);
      for (int i = 0; i < n; i++) begin
         send(random_item(), $urandom_range(3) == 0 ? 0 : $urandom_range(10));
      end
   endtask

   initial begin
      vtx_cmd_t dir[$];
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      while (busy) @(posedge clock);

      // read of a fresh vertex gives the default
      dir.push_back(load_item(0, 0, 0, 0, 0, 0, 16384, 0, 0));
      dir.push_back(idx_item(CMD_READ, 0, 0, 0));
      dir.push_back(load_item(1, 65536, 0, 0, 0, 0, 16384, 65536, 0));
      dir.push_back(load_item(2, 0, 65536, 0, 0, 0, 16384, 0, 65536));
      dir.push_back(idx_item(CMD_TRI, 0, 1, 2));
      dir.push_back(idx_item(CMD_READ, 1, 0, 0));
      // repeated corner
      dir.push_back(idx_item(CMD_TRI, 0, 0, 1));
      dir.push_back(idx_item(CMD_TRI, 2, 1, 1));
      // extremes of position, uv and normal
      dir.push_back(load_item(3, 8388607, -8388608, 8388607, -16384, 0, 0, -8388608, 8388607));
      dir.push_back(load_item(1023, -8388608, 8388607, -8388608, 0, -16384, 0, 8388607,
                              -8388608));
      dir.push_back(load_item(4, 1, -1, 0, 16384, 0, 0, 1, -1));
      dir.push_back(idx_item(CMD_TRI, 3, 1023, 4));
      dir.push_back(idx_item(CMD_TRI, 3, 1023, 4));
      dir.push_back(idx_item(CMD_READ, 3, 0, 0));
      dir.push_back(idx_item(CMD_READ, 1023, 0, 0));
      // degenerate: all uv equal
      dir.push_back(load_item(5, 100, 2000, 30000, 0, 16384, 0, 0, 0));
      dir.push_back(idx_item(CMD_TRI, 0, 5, 0));
      dir.push_back(idx_item(CMD_READ, 5, 0, 0));
      // tangent along the normal, projection collapses
      dir.push_back(load_item(10, 0, 0, 0, 0, 0, 16384, 0, 0));
      dir.push_back(load_item(11, 0, 0, 65536, 0, 0, 16384, 65536, 0));
      dir.push_back(load_item(12, 0, 0, 0, 0, 0, 16384, 0, 65536));
      dir.push_back(idx_item(CMD_TRI, 10, 11, 12));
      dir.push_back(idx_item(CMD_READ, 10, 0, 0));
      dir.push_back(noise_item(CMD_NONE));
      foreach (dir[i]) send(dir[i], $urandom_range(10));
      // fill the working set so every pick is a written vertex
      for (int vi = 0; vi < 32; vi++) begin
         if (!loaded[vi]) begin
            vtx_cmd_t it;
            it = random_item();
            while (it.cmd != CMD_LOAD) it = random_item();
            it.ia = vi;
            send(it, $urandom_range(10));
         end
      end

      run_random(PHASE_ITEMS);
      settle();
      csr_write(0, 0);
      csr_write(1, 0);
      run_random(PHASE_ITEMS);
      settle();
      csr_write(0, 24'hFFFFFF);
      csr_write(1, 24'hFFFFFF);
      run_random(PHASE_ITEMS / 2);
      settle();
      csr_write(0, $urandom_range(65535));
      csr_write(1, $urandom_range(200000));
      run_random(PHASE_ITEMS);
      settle();
      csr_write(0, 1);
      csr_write(1, $urandom_range(1) ? 1 : $urandom_range(5000));
      run_random(PHASE_ITEMS);
      settle();

      if (sb.errors == 0 && sb.frames_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/pvtf_pkg.sv
hdl/per_vertex_tangent_frame_top.sv
verif/per_vertex_tangent_frame_top_tb.sv
